[rtl/ffha_pkg.sv]
// Package for the first-fit heap allocator: constants, request and result types.
// Used by every module of the block. No dependencies.
package ffha_pkg;

	localparam int HeapBytes   = 4096;
	localparam int HeaderBytes = 24;
	localparam int Slots       = HeapBytes / 8;
	localparam int SlotW       = $clog2(Slots);
	// Offsets and sizes are carried wide enough to hold sums beyond the heap.
	localparam int OffW        = $clog2(HeapBytes) + 2;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_LEAK  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_NOTSTART = 2'd2;
	localparam logic [1:0] ST_DOUBLE   = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] alloc_bytes;
		logic [12:0] free_offset;
		logic        free_is_null;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] payload_offset;
		logic [7:0]  used_chunks;
		logic [11:0] used_bytes;
	} rsp_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;      // latch request, reset walk pointer to zero
		logic rd;        // issue header read at current pointer
		logic rd_next;   // issue header read at the successor of the current chunk
		logic step;      // advance pointer to successor
		logic alloc_wr;  // write allocated chunk (trimmed to the request when splitting)
		logic split_wr;  // write split remainder header
		logic free_wr;   // mark current chunk free
		logic rewind;    // return walk pointer and guard to the heap start
		logic merge_wr;  // absorb successor into current chunk
		logic leak_acc;  // accumulate current chunk into leak counters if it is in use
		logic done;      // capture result
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic in_heap;    // current chunk header fits inside heap
		logic next_ok;    // successor header fits inside heap
		logic fits;       // current chunk is free and large enough
		logic do_split;   // remainder takes a header plus 8 bytes
		logic is_target;  // current payload start equals free offset
		logic cur_free;
		logic nxt_free;
		logic guard_ok;   // walk guard not exhausted
	} sts_t;

endpackage

[rtl/ffha_datapath.sv]
// Datapath of the first-fit heap allocator: chunk stores, walk pointer, counters.
// Depends on ffha_pkg.
module ffha_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  ffha_pkg::req_t req,
	input  ffha_pkg::cmd_t cmd,
	input  logic [1:0]     res_status,
	output ffha_pkg::sts_t sts,
	output ffha_pkg::rsp_t rsp
);
	import ffha_pkg::*;

	logic [12:0]       size_mem [Slots];
	logic              free_mem [Slots];

	req_t              req_q;
	logic [OffW-1:0]   off_q;
	logic [OffW-1:0]   need_q;
	logic [12:0]       cur_size_q;
	logic              cur_free_q;
	logic              nxt_free_q;
	logic [12:0]       nxt_size_q;
	logic [SlotW:0]    guard_q;
	logic [7:0]        lchunks_q;
	logic [11:0]       lbytes_q;
	logic              init_q;
	rsp_t              rsp_q;

	logic [OffW-1:0]   next_off;
	logic [OffW-1:0]   split_off;
	logic [OffW-1:0]   rest;
	logic [SlotW-1:0]  rd_slot;
	logic [SlotW-1:0]  cur_slot;
	logic              rd_init;

	// Successor offset and split arithmetic from the registered header.
	assign next_off  = off_q + OffW'(HeaderBytes) + OffW'(cur_size_q);
	assign split_off = off_q + OffW'(HeaderBytes) + need_q;
	assign rest      = OffW'(cur_size_q) - need_q;
	assign cur_slot  = off_q[SlotW+2:3];
	assign rd_slot   = cmd.rd_next ? next_off[SlotW+2:3] : cur_slot;

	// Entry zero reads as the reset chunk until it is first written.
	assign rd_init = (rd_slot == '0) && init_q;

	// Status toward the controller.
	assign sts.in_heap   = (off_q + OffW'(HeaderBytes)) <= OffW'(HeapBytes);
	assign sts.next_ok   = (next_off + OffW'(HeaderBytes)) <= OffW'(HeapBytes);
	assign sts.fits      = cur_free_q && (OffW'(cur_size_q) >= need_q);
	assign sts.do_split  = rest >= OffW'(HeaderBytes + 8);
	assign sts.is_target = (off_q + OffW'(HeaderBytes)) == OffW'(req_q.free_offset);
	assign sts.cur_free  = cur_free_q;
	assign sts.nxt_free  = nxt_free_q;
	assign sts.guard_ok  = guard_q <= (SlotW+1)'(Slots);

	// Chunk stores: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.alloc_wr) begin
			free_mem[cur_slot] <= 1'b0;
			if (sts.do_split)
				size_mem[cur_slot] <= need_q[12:0];
			else
				size_mem[cur_slot] <= cur_size_q;
		end else if (cmd.split_wr) begin
			size_mem[split_off[SlotW+2:3]] <= 13'(rest - OffW'(HeaderBytes));
			free_mem[split_off[SlotW+2:3]] <= 1'b1;
		end else if (cmd.free_wr) begin
			free_mem[cur_slot] <= 1'b1;
			size_mem[cur_slot] <= cur_size_q;
		end else if (cmd.merge_wr) begin
			size_mem[cur_slot] <= 13'(cur_size_q + 13'(HeaderBytes) + nxt_size_q);
			free_mem[cur_slot] <= cur_free_q;
		end
		if (cmd.rd) begin
			cur_size_q <= rd_init ? 13'(HeapBytes - HeaderBytes) : size_mem[rd_slot];
			cur_free_q <= rd_init ? 1'b1 : free_mem[rd_slot];
		end
		if (cmd.rd_next) begin
			nxt_size_q <= rd_init ? 13'(HeapBytes - HeaderBytes) : size_mem[rd_slot];
			nxt_free_q <= rd_init ? 1'b1 : free_mem[rd_slot];
		end
		if (cmd.merge_wr)
			cur_size_q <= 13'(cur_size_q + 13'(HeaderBytes) + nxt_size_q);
		if (cmd.free_wr)
			cur_free_q <= 1'b1;
	end

	// Reset-chunk flag: cleared on the first write to entry zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b1;
		end else if ((cmd.alloc_wr || cmd.free_wr || cmd.merge_wr) && cur_slot == '0) begin
			init_q <= 1'b0;
		end
	end

	// Walk pointer, guard and leak counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			guard_q   <= '0;
			lchunks_q <= '0;
			lbytes_q  <= '0;
		end else if (cmd.load) begin
			off_q     <= '0;
			guard_q   <= '0;
			lchunks_q <= '0;
			lbytes_q  <= '0;
		end else if (cmd.rewind) begin
			off_q   <= '0;
			guard_q <= '0;
		end else begin
			if (cmd.step) begin
				off_q   <= next_off;
				guard_q <= guard_q + (SlotW+1)'(1);
			end
			if (cmd.merge_wr)
				guard_q <= guard_q + (SlotW+1)'(1);
			if (cmd.leak_acc && !cur_free_q) begin
				lchunks_q <= lchunks_q + 8'd1;
				lbytes_q  <= lbytes_q + cur_size_q[11:0];
			end
		end
	end

	// Request latch and result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req;
			need_q <= (req.alloc_bytes > 16'(HeapBytes)) ? OffW'(HeapBytes) :
				((OffW'(req.alloc_bytes) + OffW'(7)) & ~OffW'(7));
		end
		if (cmd.done) begin
			rsp_q.status         <= res_status;
			rsp_q.payload_offset <= (req_q.req_type == REQ_ALLOC && res_status == ST_OK) ?
				12'(off_q + OffW'(HeaderBytes)) : 12'd0;
			rsp_q.used_chunks    <= (req_q.req_type == REQ_LEAK) ? lchunks_q : 8'd0;
			rsp_q.used_bytes     <= (req_q.req_type == REQ_LEAK) ? lbytes_q : 12'd0;
		end
	end

	assign rsp = rsp_q;

endmodule

[rtl/ffha_ctrl.sv]
// Controller of the first-fit heap allocator: sequences walks, writes and merges.
// Depends on ffha_pkg.
module ffha_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ffha_pkg::req_t req,
	output logic           out_valid,
	input  logic           out_stall,
	input  ffha_pkg::sts_t sts,
	output ffha_pkg::cmd_t cmd,
	output logic [1:0]     res_status
);
	import ffha_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_READ  = 11'b00000000010,
		S_EVAL  = 11'b00000000100,
		S_SPLIT = 11'b00000001000,
		S_MRD   = 11'b00000010000,
		S_MRDN  = 11'b00000100000,
		S_MEVAL = 11'b00001000000,
		S_DONE  = 11'b00010000000,
		S_OUT   = 11'b00100000000,
		S_MSTEP = 11'b01000000000,
		S_FREE  = 11'b10000000000
	} state_t;

	state_t     state_q;
	logic [1:0] kind_q;
	logic [1:0] st_q;
	logic       accept;

	assign in_stall   = (state_q != S_IDLE) && !(state_q == S_OUT && !out_stall);
	assign accept     = in_valid && !in_stall;
	assign out_valid  = (state_q == S_OUT);
	assign res_status = st_q;

	// Command decode per state.
	always_comb begin
		cmd = '0;
		cmd.load = accept;
		case (state_q)
			S_READ:  cmd.rd = 1'b1;
			S_EVAL: begin
				case (kind_q)
					REQ_ALLOC: begin
						if (sts.in_heap && sts.guard_ok) begin
							if (sts.fits) cmd.alloc_wr = 1'b1;
							else cmd.step = 1'b1;
						end
					end
					REQ_FREE: begin
						if (sts.in_heap && sts.guard_ok) begin
							if (sts.is_target) begin
								if (!sts.cur_free) cmd.free_wr = 1'b1;
							end else begin
								cmd.step = 1'b1;
							end
						end
					end
					REQ_LEAK: begin
						if (sts.in_heap && sts.guard_ok) begin
							cmd.leak_acc = 1'b1;
							cmd.step = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_SPLIT: cmd.split_wr = 1'b1;
			// Coalescing walks the whole chain from the heap start.
			S_FREE:  cmd.rewind = 1'b1;
			S_MRD:   cmd.rd = 1'b1;
			S_MRDN:  cmd.rd_next = 1'b1;
			S_MEVAL: begin
				if (sts.in_heap && sts.guard_ok && sts.next_ok) begin
					if (sts.cur_free && sts.nxt_free) cmd.merge_wr = 1'b1;
				end
			end
			S_MSTEP: cmd.step = 1'b1;
			S_DONE:  cmd.done = 1'b1;
			default: ;
		endcase
	end

	// State register and sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= REQ_ALLOC;
			st_q    <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE, S_OUT: begin
					if (accept) begin
						kind_q <= req.req_type;
						st_q   <= (req.req_type == REQ_ALLOC) ? ST_NOFIT : ST_OK;
						if (req.req_type == REQ_ALLOC) begin
							state_q <= S_READ;
						end else if (req.req_type == REQ_LEAK ||
							(req.req_type == REQ_FREE && !req.free_is_null)) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_DONE;
						end
					end else if (state_q == S_OUT && !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					if (!(sts.in_heap && sts.guard_ok)) begin
						if (kind_q == REQ_FREE) st_q <= ST_NOTSTART;
						state_q <= S_DONE;
					end else begin
						case (kind_q)
							REQ_ALLOC: begin
								if (sts.fits) begin
									st_q    <= ST_OK;
									state_q <= sts.do_split ? S_SPLIT : S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							REQ_FREE: begin
								if (sts.is_target) begin
									if (sts.cur_free) begin
										st_q    <= ST_DOUBLE;
										state_q <= S_DONE;
									end else begin
										state_q <= S_FREE;
									end
								end else begin
									state_q <= S_READ;
								end
							end
							default: state_q <= S_READ;
						endcase
					end
				end
				S_SPLIT: state_q <= S_DONE;
				S_FREE:  state_q <= S_MRD;
				S_MRD:   state_q <= S_MRDN;
				S_MRDN:  state_q <= S_MEVAL;
				S_MEVAL: begin
					if (!(sts.in_heap && sts.guard_ok && sts.next_ok))
						state_q <= S_DONE;
					else if (sts.cur_free && sts.nxt_free)
						state_q <= S_MRDN;
					else
						state_q <= S_MSTEP;
				end
				S_MSTEP: state_q <= S_MRD;
				S_DONE:  state_q <= S_OUT;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_datapath.
//
//   Channel | Handshake            | Payload
//   req     | req_valid, req_stall | ffha_pkg::req_t
//   rsp     | rsp_valid, rsp_stall | ffha_pkg::rsp_t
//
// One item at a time. Each chunk header walked is read from the store and then
// evaluated; a split adds a write of the remainder, then the result is captured and presented.
// A successful free then rewinds and coalesces from the heap start: for each chunk
// it reads the current header, reads its successor and evaluates, merging or stepping on.
// The chunk store has a single read port, so the two headers are read in turn.
// Reset leaves the heap as one free chunk and needs no clearing pass.
// A stalled result holds the block; a new item is taken in the cycle its
// predecessor's result leaves.
module first_fit_heap_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ffha_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ffha_pkg::rsp_t rsp
);
	import ffha_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [1:0] res_status;

	ffha_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req_valid),
		.in_stall   (req_stall),
		.req        (req),
		.out_valid  (rsp_valid),
		.out_stall  (rsp_stall),
		.sts        (sts),
		.cmd        (cmd),
		.res_status (res_status)
	);

	ffha_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cmd        (cmd),
		.res_status (res_status),
		.sts        (sts),
		.rsp        (rsp)
	);

endmodule
